// ===== hdl/fdaj_pkg.sv =====
// Shared types and constants for the feeder disk angle and jam controller.
package fdaj_pkg;

  localparam int ANGLE_FRAC_BITS = 8;

  localparam int RPM_W      = 15;
  localparam int SHOT_W     = 12;
  localparam int RATE_W     = 14;
  localparam int AIM_W      = 2;
  localparam int SPEED_W    = 15;
  localparam int ANGLE_W    = 32;
  localparam int DEG_W      = 9;
  localparam int GAIN_W     = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = RPM_W + GAIN_W + 1;
  localparam int STEP_W     = PROD_W - 16;
  localparam int TGT_W      = SHOT_W + DEG_W + ANGLE_FRAC_BITS;
  localparam int ERR_W      = ((TGT_W > ANGLE_W) ? TGT_W : ANGLE_W) + 2;
  localparam int STALL_W    = 10;
  localparam int REV_W      = 9;

  localparam int DROP_STEP = (1 << ANGLE_FRAC_BITS) / 100;

  localparam logic signed [SPEED_W-1:0] SPEED_BACK = -15'sd3500;
  localparam logic signed [SPEED_W-1:0] SPEED_JAM  = -15'sd5000;
  localparam logic signed [RPM_W-1:0]   STALL_RPM  = 15'sd50;
  localparam logic [STALL_W-1:0]        STALL_FAST = 10'd300;
  localparam logic [STALL_W-1:0]        STALL_SLOW = 10'd500;
  localparam logic [REV_W-1:0]          REVERSE_LEN = 9'd300;
  localparam int                        GAP_DEG    = 10;

  localparam logic [AIM_W-1:0] AIM_FAST1 = 2'd1;
  localparam logic [AIM_W-1:0] AIM_FAST2 = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SHOT_ANGLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN = 1'b1;

  localparam logic [DEG_W-1:0]  SHOT_ANGLE_RST = 9'd45;
  localparam logic [GAIN_W-1:0] ANGLE_GAIN_RST = 24'd16777;

  // Classified tick handed from the front end to the back end.
  typedef struct packed {
    logic signed [STEP_W-1:0] step;
    logic [TGT_W-1:0]         target;
    logic [RATE_W-1:0]        rate;
    logic                     fast;
    logic                     stall_cond;
    logic                     reset_angle;
    logic                     clear_speed;
  } fdaj_item_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] target_speed;
    logic                      jam_active;
    logic                      clear_counts;
    logic signed [ANGLE_W-1:0] plate_angle;
  } fdaj_result_t;

endpackage

// ===== hdl/fdaj_front.sv =====
// Front end: config registers, angle step multiply, target angle, classification.
module fdaj_front
  import fdaj_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic signed [RPM_W-1:0]  motor_speed_rpm_i,
  input  logic [SHOT_W-1:0]        shot_count_i,
  input  logic [RATE_W-1:0]        firing_rate_i,
  input  logic                     continuous_mode_i,
  input  logic [AIM_W-1:0]         aim_mode_i,
  input  logic                     reset_angle_i,
  input  logic                     clear_speed_i,
  output logic                     valid_o,
  output fdaj_item_t               item_o,
  input  logic                     stall_i
);

  localparam logic signed [STEP_W-1:0] DropPos = STEP_W'(DROP_STEP);
  localparam logic signed [STEP_W-1:0] DropNeg = -STEP_W'(DROP_STEP);

  logic [DEG_W-1:0]          shot_angle_q;
  logic [GAIN_W-1:0]         angle_gain_q;
  logic                      valid_q, valid_d;
  fdaj_item_t                item_q, item_d;
  logic                      accept;
  logic signed [PROD_W-1:0]  prod;
  logic signed [STEP_W-1:0]  step;
  logic [SHOT_W+DEG_W-1:0]   shot_deg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shot_angle_q <= SHOT_ANGLE_RST;
      angle_gain_q <= ANGLE_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHOT_ANGLE: shot_angle_q <= cfg_data_i[DEG_W-1:0];
        CFG_ANGLE_GAIN: angle_gain_q <= cfg_data_i[GAIN_W-1:0];
        default:        shot_angle_q <= shot_angle_q;
      endcase
    end
  end

  assign full_o = valid_q && stall_i;
  assign accept = push_i && !full_o;

  always_comb begin
    prod = PROD_W'(motor_speed_rpm_i) * $signed({{(PROD_W-GAIN_W){1'b0}}, angle_gain_q});
    // Arithmetic shift floors toward minus infinity.
    step = prod[PROD_W-1:16];
    shot_deg = (SHOT_W+DEG_W)'(shot_count_i) * (SHOT_W+DEG_W)'(shot_angle_q);

    item_d.step        = ((step > DropPos) || (step < DropNeg)) ? step : '0;
    item_d.target      = {shot_deg, {ANGLE_FRAC_BITS{1'b0}}};
    item_d.rate        = firing_rate_i;
    item_d.fast        = (aim_mode_i == AIM_FAST1) || (aim_mode_i == AIM_FAST2);
    item_d.stall_cond  = (motor_speed_rpm_i < STALL_RPM) &&
                         (continuous_mode_i || (aim_mode_i == AIM_FAST1));
    item_d.reset_angle = reset_angle_i;
    item_d.clear_speed = clear_speed_i;

    valid_d = accept || (valid_q && stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/fdaj_queue.sv =====
// Two-entry queue of classified ticks between the front and back ends.
module fdaj_queue
  import fdaj_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  fdaj_item_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output fdaj_item_t data_o,
  output logic       empty_o
);

  fdaj_item_t  mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/fdaj_back.sv =====
// Back end: angle integration, speed decision, stall and jam sequencing, result buffer.
module fdaj_back
  import fdaj_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  fdaj_item_t   item_i,
  output logic         take_o,
  output logic         empty_o,
  input  logic         pop_i,
  output fdaj_result_t res_o
);

  localparam logic signed [ERR_W-1:0] FinishFast = ERR_W'(1) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ERR_W-1:0] FinishSlow = ERR_W'(5) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ERR_W-1:0] GapPos     = ERR_W'(GAP_DEG) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ERR_W-1:0] GapNeg     = -GapPos;
  localparam logic signed [ANGLE_W-1:0] AngleMax = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] AngleMin = {1'b1, {(ANGLE_W-1){1'b0}}};

  logic signed [ANGLE_W-1:0] acc_q, acc_d, acc_base;
  logic signed [SPEED_W-1:0] held_q, held_d, held_base;
  logic                      jam_q, jam_d;
  logic [STALL_W-1:0]        stall_q, stall_d, stall_inc, stall_lim;
  logic [REV_W-1:0]          rev_q, rev_d, rev_inc;
  logic                      clr;
  logic signed [ANGLE_W:0]   sum;
  logic signed [ERR_W-1:0]   err, finish;
  logic                      fire;

  fdaj_result_t res_mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         do_pop;

  assign take_o  = valid_i && (cnt_q != 2'd2);
  assign fire    = take_o;
  assign empty_o = (cnt_q == 2'd0);
  assign do_pop  = pop_i && !empty_o;
  assign res_o   = res_mem_q[rd_ptr_q];

  always_comb begin
    acc_base = item_i.reset_angle ? '0 : acc_q;
    sum      = (ANGLE_W+1)'(acc_base) + (ANGLE_W+1)'(item_i.step);
    // Saturate on signed overflow.
    if (sum[ANGLE_W] != sum[ANGLE_W-1]) begin
      acc_d = sum[ANGLE_W] ? AngleMin : AngleMax;
    end else begin
      acc_d = sum[ANGLE_W-1:0];
    end

    held_base = item_i.clear_speed ? '0 : held_q;
    err       = $signed({{(ERR_W-TGT_W){1'b0}}, item_i.target}) - ERR_W'(acc_d);
    finish    = item_i.fast ? FinishFast : FinishSlow;
    stall_lim = item_i.fast ? STALL_FAST : STALL_SLOW;
    stall_inc = stall_q + 1'b1;
    rev_inc   = rev_q + 1'b1;

    held_d  = held_base;
    jam_d   = jam_q;
    stall_d = stall_q;
    rev_d   = rev_q;
    clr     = 1'b0;

    if (!jam_q) begin
      priority if (err >= 0 && err <= finish) begin
        held_d = '0;
      end else if (err < GapNeg) begin
        held_d = SPEED_BACK;
      end else if (err > GapPos) begin
        held_d = $signed({1'b0, item_i.rate});
        if (item_i.stall_cond) begin
          if (stall_inc > stall_lim) begin
            jam_d   = 1'b1;
            stall_d = '0;
          end else begin
            stall_d = stall_inc;
          end
        end else begin
          stall_d = '0;
        end
      end else begin
        held_d = held_base;
      end
    end else begin
      held_d = SPEED_JAM;
      // Finish the reverse phase and request a count clear.
      if (rev_inc > REVERSE_LEN) begin
        jam_d = 1'b0;
        rev_d = '0;
        clr   = 1'b1;
      end else begin
        rev_d = rev_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      held_q   <= '0;
      jam_q    <= 1'b0;
      stall_q  <= '0;
      rev_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (fire) begin
        acc_q    <= acc_d;
        held_q   <= held_d;
        jam_q    <= jam_d;
        stall_q  <= stall_d;
        rev_q    <= rev_d;
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(fire) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_mem_q[wr_ptr_q] <= '{target_speed: held_d, jam_active: jam_d,
                               clear_counts: clr, plate_angle: acc_d};
    end
  end

endmodule

// ===== hdl/feeder_disk_angle_jam_controller_unit.sv =====
// Feeder disk angle and jam controller, top level.
// An accepted tick is registered in the front stage, mid queue and result buffer,
// where it shows (empty low). Throughput: one tick per cycle, set by the angle and
// decision update in the back end; a two-entry queue between the ends and a
// two-entry result buffer let either side stall. Reset: async, active low; clears
// angle, held speed, jam and counters; loads shot angle 45 degrees and gain 16777.
module feeder_disk_angle_jam_controller_unit
  import fdaj_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      push,
  output logic                      full,
  input  logic signed [RPM_W-1:0]   motor_speed_rpm_i,
  input  logic [SHOT_W-1:0]         shot_count_i,
  input  logic [RATE_W-1:0]         firing_rate_i,
  input  logic                      continuous_mode_i,
  input  logic [AIM_W-1:0]          aim_mode_i,
  input  logic                      reset_angle_i,
  input  logic                      clear_speed_i,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [SPEED_W-1:0] target_speed_o,
  output logic                      jam_active_o,
  output logic                      clear_counts_o,
  output logic signed [ANGLE_W-1:0] plate_angle_o
);

  logic         front_valid;
  fdaj_item_t   front_item;
  logic         mid_full, mid_empty, back_take;
  fdaj_item_t   mid_item;
  fdaj_result_t res;

  fdaj_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .push_i            (push),
    .full_o            (full),
    .motor_speed_rpm_i (motor_speed_rpm_i),
    .shot_count_i      (shot_count_i),
    .firing_rate_i     (firing_rate_i),
    .continuous_mode_i (continuous_mode_i),
    .aim_mode_i        (aim_mode_i),
    .reset_angle_i     (reset_angle_i),
    .clear_speed_i     (clear_speed_i),
    .valid_o           (front_valid),
    .item_o            (front_item),
    .stall_i           (mid_full)
  );

  fdaj_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .full_o  (mid_full),
    .pop_i   (back_take),
    .data_o  (mid_item),
    .empty_o (mid_empty)
  );

  fdaj_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!mid_empty),
    .item_i  (mid_item),
    .take_o  (back_take),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res)
  );

  assign target_speed_o = res.target_speed;
  assign jam_active_o   = res.jam_active;
  assign clear_counts_o = res.clear_counts;
  assign plate_angle_o  = res.plate_angle;

`ifndef SYNTHESIS
  a_accept_loads_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> front_valid)
    else $error("accepted tick not held in front stage");

  a_mid_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mid_full && mid_empty))
    else $error("mid queue both full and empty");

  a_clear_ends_jam: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && clear_counts_o) |-> !jam_active_o)
    else $error("count clear flagged while jam still active");
`endif

endmodule
